// ----- sv/twsm_pkg.sv -----
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared types and defaults for the two-way sorted merge.
// ----------------------------------------------------------------------------
package twsm_pkg;

  localparam int KEY_BYTES_DEF = 8;
  localparam int TAG_BITS_DEF  = 32;

  typedef enum logic {
    STREAM_A = 1'b0,
    STREAM_B = 1'b1
  } stream_t;

  // number of result words produced by one input word (0..2)
  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    logic [1:0] head_valid;
    logic [1:0] ended;
  } merge_flags_t;

endpackage

// ----- sv/twsm_step.sv -----
// ----------------------------------------------------------------------------
// twsm_step
// Merge decision for one input word: head update, up to two result words
// (protocol error, emitted heads, done) and the next flag state.
// ----------------------------------------------------------------------------
module twsm_step #(
  parameter int KEY_BYTES = twsm_pkg::KEY_BYTES_DEF,
  parameter int TAG_BITS  = twsm_pkg::TAG_BITS_DEF,
  parameter int RES_W     = KEY_BYTES * 8 + TAG_BITS + 3
) (
  input  twsm_pkg::merge_flags_t              flags,
  input  logic [1:0][KEY_BYTES*8-1:0]         head_key,
  input  logic [1:0][TAG_BITS-1:0]            head_tag,
  input  logic                                stream_id,
  input  logic                                end_of_stream,
  input  logic [KEY_BYTES*8-1:0]              record_key,
  input  logic [TAG_BITS-1:0]                 record_tag,
  output twsm_pkg::merge_flags_t              flags_next,
  output logic                                load,
  output twsm_pkg::res_cnt_t                  res_cnt,
  output logic [RES_W-1:0]                    res0,
  output logic [RES_W-1:0]                    res1
);
  import twsm_pkg::*;

  localparam int KW = KEY_BYTES * 8;

  logic [1:0]          hv, en, ld_vec, eos_vec, hv1, en1, hv2, hv3;
  logic                err, pick1_ok, pick2_ok, done;
  stream_t             p1, p2;
  logic [KW-1:0]       k0, k1;
  logic [TAG_BITS-1:0] t0, t1;
  logic [RES_W-1:0]    rec_err, rec1, rec2, rec_done;

  always_comb begin
    hv      = flags.head_valid;
    en      = flags.ended;
    err     = !end_of_stream && (hv[stream_id] || en[stream_id]);
    load    = !end_of_stream && !hv[stream_id] && !en[stream_id];
    ld_vec  = load ? (2'b01 << stream_id) : 2'b00;
    eos_vec = end_of_stream ? (2'b01 << stream_id) : 2'b00;
    hv1     = hv | ld_vec;
    en1     = en | eos_vec;
    k0      = ld_vec[0] ? record_key : head_key[0];
    k1      = ld_vec[1] ? record_key : head_key[1];
    t0      = ld_vec[0] ? record_tag : head_tag[0];
    t1      = ld_vec[1] ? record_tag : head_tag[1];

    pick1_ok = 1'b1;
    p1       = STREAM_A;
    priority if (hv1 == 2'b11) begin
      p1 = (k0 <= k1) ? STREAM_A : STREAM_B;
    end else if (hv1[0] && en1[1]) begin
      p1 = STREAM_A;
    end else if (hv1[1] && en1[0]) begin
      p1 = STREAM_B;
    end else begin
      pick1_ok = 1'b0;
    end

    p2       = stream_t'(~p1);
    hv2      = hv1 & ~(pick1_ok ? (2'b01 << p1) : 2'b00);
    pick2_ok = !err && pick1_ok && hv2[p2] && en1[p1];
    hv3      = hv2 & ~(pick2_ok ? (2'b01 << p2) : 2'b00);
    done     = !(pick2_ok || (err && pick1_ok)) && (en1 == 2'b11) && (hv3 == 2'b00);

    res_cnt = res_cnt_t'({1'b0, err}) + res_cnt_t'({1'b0, pick1_ok})
            + res_cnt_t'({1'b0, pick2_ok}) + res_cnt_t'({1'b0, done});

    if (done) begin
      flags_next = '0;
    end else begin
      flags_next.head_valid = hv3;
      flags_next.ended      = en1;
    end

    rec_err  = {stream_id, {KW{1'b0}}, {TAG_BITS{1'b0}}, 1'b0, 1'b1};
    rec1     = {p1, (p1 == STREAM_B) ? k1 : k0, (p1 == STREAM_B) ? t1 : t0, 2'b00};
    rec2     = {p2, (p2 == STREAM_B) ? k1 : k0, (p2 == STREAM_B) ? t1 : t0, 2'b00};
    rec_done = {STREAM_A, {KW{1'b0}}, {TAG_BITS{1'b0}}, 1'b1, 1'b0};

    if (err) begin
      res0 = rec_err;
      res1 = pick1_ok ? rec1 : rec_done;
    end else begin
      res0 = pick1_ok ? rec1 : rec_done;
      res1 = pick2_ok ? rec2 : rec_done;
    end
  end

endmodule

// ----- sv/twsm_outq.sv -----
// ----------------------------------------------------------------------------
// twsm_outq
// Four-entry result queue: pushes up to two words per cycle, pops one when out_stall is low.
// ----------------------------------------------------------------------------
module twsm_outq #(
  parameter int WIDTH = 99
) (
  input  logic               clk,
  input  logic               rst,
  input  twsm_pkg::res_cnt_t push_cnt,
  input  logic [WIDTH-1:0]   push0,
  input  logic [WIDTH-1:0]   push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WIDTH-1:0]   out_data
);
  import twsm_pkg::*;

  logic [3:0][WIDTH-1:0] mem;
  logic [1:0]            wr_ptr, rd_ptr, wr_ptr1;
  logic [2:0]            count, count_next;
  logic                  pop;

  assign pop        = out_valid && !out_stall;
  assign wr_ptr1    = wr_ptr + 2'd1;
  assign count_next = count + {1'b0, push_cnt} - {2'b00, pop};
  assign out_valid  = (count != 3'd0);
  assign room       = (count <= 3'd2);
  assign out_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

endmodule

// ----- sv/two_way_sorted_merge.sv -----
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// Merges two presorted record streams (A and B) into one stream sorted by
// unsigned key, ties to A.
//
// Input channel (in_valid / in_stall): each word carries either the next
// record for stream_id or an end-of-stream mark for it. Output channel
// (out_valid / out_stall): one result word per handshake, either an emitted
// record, a protocol error for a record sent to a full or ended stream, or
// merge_done once both streams are ended and drained.
// Results of an accepted word are registered into the result queue.
// The block takes one input word per cycle while in_stall is low; a word
// yielding two results leaves the single-pop result queue one at a time.
// The four-entry result queue raises in_stall when three or more results
// are waiting, so a stalled receiver backs up into the input after at most
// four queued results. Reset clears heads, stream state and the queue.
// ----------------------------------------------------------------------------
module two_way_sorted_merge #(
  parameter int KEY_BYTES = twsm_pkg::KEY_BYTES_DEF,
  parameter int TAG_BITS  = twsm_pkg::TAG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   stream_id,
  input  logic                   end_of_stream,
  input  logic [KEY_BYTES*8-1:0] record_key,
  input  logic [TAG_BITS-1:0]    record_tag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_stream,
  output logic [KEY_BYTES*8-1:0] out_key,
  output logic [TAG_BITS-1:0]    out_tag,
  output logic                   merge_done,
  output logic                   protocol_error
);
  import twsm_pkg::*;

  localparam int KW    = KEY_BYTES * 8;
  localparam int RES_W = KW + TAG_BITS + 3;

  merge_flags_t             flags, flags_next;
  logic [1:0][KW-1:0]       head_key;
  logic [1:0][TAG_BITS-1:0] head_tag;
  logic                     load, accept, room;
  res_cnt_t                 res_cnt, push_cnt;
  logic [RES_W-1:0]         res0, res1, q_data;

  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;
  assign push_cnt = accept ? res_cnt : 2'd0;

  twsm_step #(
    .KEY_BYTES (KEY_BYTES),
    .TAG_BITS  (TAG_BITS),
    .RES_W     (RES_W)
  ) u_step (
    .flags         (flags),
    .head_key      (head_key),
    .head_tag      (head_tag),
    .stream_id     (stream_id),
    .end_of_stream (end_of_stream),
    .record_key    (record_key),
    .record_tag    (record_tag),
    .flags_next    (flags_next),
    .load          (load),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  twsm_outq #(
    .WIDTH (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign {out_stream, out_key, out_tag, merge_done, protocol_error} = q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (accept) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load) begin
      head_key[stream_id] <= record_key;
      head_tag[stream_id] <= record_tag;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for two_way_sorted_merge. Runs a short directed pass over ties,
// extreme keys, full and ended streams and idle end marks, then random
// merges of presorted streams mixed with noise and unsorted sequences. A
// scoreboard class predicts every result word and checks the output stream
// in order; both channels idle and stall at random except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import twsm_pkg::*;

  localparam int KEY_W = KEY_BYTES_DEF * 8;
  localparam int TAG_W = TAG_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    stream_t          strm;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             done;
    logic             err;
  } merge_result_t;

  class merge_scoreboard;
    bit [KEY_W-1:0] head_key [2];
    bit [TAG_W-1:0] head_tag [2];
    bit [1:0]       head_valid;
    bit [1:0]       ended;
    merge_result_t  expected_out [$];
    int             mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      head_valid = '0;
      ended      = '0;
    endfunction

    function bit busy();
      return (head_valid != 0) || (ended != 0);
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void push_expected(bit s, bit [KEY_W-1:0] k, bit [TAG_W-1:0] t,
                                bit d, bit e);
      merge_result_t r;
      r.strm = stream_t'(s);
      r.key  = k;
      r.tag  = t;
      r.done = d;
      r.err  = e;
      expected_out.push_back(r);
    endfunction

    function int pick_head();
      if (head_valid[0] && head_valid[1])
        return (head_key[0] <= head_key[1]) ? 0 : 1;
      if (head_valid[0] && ended[1])
        return 0;
      if (head_valid[1] && ended[0])
        return 1;
      return -1;
    endfunction

    function void note_word(bit sid, bit eos, bit [KEY_W-1:0] key, bit [TAG_W-1:0] tag);
      int n;
      int p;
      n = 0;
      if (eos) begin
        ended[sid] = 1'b1;
      end else if (head_valid[sid] || ended[sid]) begin
        push_expected(sid, '0, '0, 1'b0, 1'b1);
        n++;
      end else begin
        head_key[sid]   = key;
        head_tag[sid]   = tag;
        head_valid[sid] = 1'b1;
      end
      while (n < 2) begin
        p = pick_head();
        if (p < 0)
          break;
        push_expected(p[0], head_key[p], head_tag[p], 1'b0, 1'b0);
        head_valid[p] = 1'b0;
        n++;
      end
      if (n < 2 && ended == 2'b11 && head_valid == 2'b00) begin
        push_expected(1'b0, '0, '0, 1'b1, 1'b0);
        clear_state();
      end
    endfunction

    function void check_word(merge_result_t got);
      merge_result_t want;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: stream=%0d key=%h tag=%h done=%0b err=%0b",
                   got.strm, got.key, got.tag, got.done, got.err);
        return;
      end
      want = expected_out.pop_front();
      if (got.strm !== want.strm || got.key !== want.key || got.tag !== want.tag ||
          got.done !== want.done || got.err !== want.err) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch exp: stream=%0d key=%h tag=%h done=%0b err=%0b",
                   want.strm, want.key, want.tag, want.done, want.err);
          $display("         got: stream=%0d key=%h tag=%h done=%0b err=%0b",
                   got.strm, got.key, got.tag, got.done, got.err);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             stream_id;
  logic             end_of_stream;
  logic [KEY_W-1:0] record_key;
  logic [TAG_W-1:0] record_tag;
  logic             out_valid;
  logic             out_stall;
  logic             out_stream;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             merge_done;
  logic             protocol_error;

  merge_scoreboard merge_sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              words_sent;
  int              quiet_cycles;

  two_way_sorted_merge uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_id     (stream_id),
    .end_of_stream (end_of_stream),
    .record_key    (record_key),
    .record_tag    (record_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_stream    (out_stream),
    .out_key       (out_key),
    .out_tag       (out_tag),
    .merge_done    (merge_done),
    .protocol_error(protocol_error)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    merge_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.strm = stream_t'(out_stream);
      got.key  = out_key;
      got.tag  = out_tag;
      got.done = merge_done;
      got.err  = protocol_error;
      merge_sb.check_word(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit [KEY_W-1:0] rand_key(int mode);
    bit [KEY_W-1:0] k;
    case (mode)
      0: k = KEY_W'($urandom_range(0, 7));
      1: k = {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = KEY_W'(1);
          default: k = ~KEY_W'(1);
        endcase
      end
    endcase
    return k;
  endfunction

  // tasks start and end on a falling edge
  task automatic send_word(bit sid, bit eos, bit [KEY_W-1:0] key, bit [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    stream_id     = sid;
    end_of_stream = eos;
    record_key    = key;
    record_tag    = tag;
    do @(posedge clk); while (in_stall);
    if (!(eos && merge_sb.ended[sid]))
      words_sent++;
    merge_sb.note_word(sid, eos, key, tag);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (merge_sb.pending() > 0)
      @(negedge clk);
  endtask

  task automatic flush_streams();
    bit s;
    while (merge_sb.busy()) begin
      if (!merge_sb.ended[0])
        s = 1'b0;
      else if (!merge_sb.ended[1])
        s = 1'b1;
      else
        s = 1'($urandom_range(0, 1));
      send_word(s, 1'b1, rand_key(1), $urandom);
    end
  endtask

  task automatic run_merge(int na, int nb, int mode, bit sorted);
    bit [KEY_W-1:0] keys_a [$];
    bit [KEY_W-1:0] keys_b [$];
    int             idx [2];
    bit [1:0]       end_sent;
    bit             s;
    int             count;
    for (int i = 0; i < na; i++)
      keys_a.push_back(rand_key(mode));
    for (int i = 0; i < nb; i++)
      keys_b.push_back(rand_key(mode));
    if (sorted) begin
      keys_a.sort();
      keys_b.sort();
    end
    idx[0]   = 0;
    idx[1]   = 0;
    end_sent = 2'b00;
    while (end_sent != 2'b11) begin
      if (merge_sb.head_valid[0] || end_sent[0])
        s = 1'b1;
      else if (merge_sb.head_valid[1] || end_sent[1])
        s = 1'b0;
      else
        s = 1'($urandom_range(0, 1));
      count = s ? nb : na;
      if (idx[s] < count) begin
        send_word(s, 1'b0, s ? keys_b[idx[s]] : keys_a[idx[s]], $urandom);
        idx[s]++;
      end else begin
        send_word(s, 1'b1, rand_key(1), $urandom);
        end_sent[s] = 1'b1;
      end
    end
  endtask

  task automatic run_noise(int n);
    for (int i = 0; i < n; i++)
      send_word(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                rand_key($urandom_range(0, 2)), $urandom);
    flush_streams();
  endtask

  task automatic run_directed();
    send_word(STREAM_A, 1'b0, '0, '0);
    send_word(STREAM_B, 1'b0, '1, '1);
    send_word(STREAM_A, 1'b0, '1, 32'h5a5a_a5a5);
    send_word(STREAM_A, 1'b1, '0, '0);
    send_word(STREAM_B, 1'b1, '1, '1);
    send_word(STREAM_A, 1'b0, KEY_W'(5), $urandom);
    send_word(STREAM_B, 1'b0, KEY_W'(3), $urandom);
    send_word(STREAM_A, 1'b0, KEY_W'(7), $urandom);
    send_word(STREAM_B, 1'b1, '0, '0);
    send_word(STREAM_B, 1'b0, KEY_W'(9), $urandom);
    send_word(STREAM_A, 1'b1, '0, '0);
    send_word(STREAM_A, 1'b1, '0, '0);
    send_word(STREAM_A, 1'b1, '0, '0);
    send_word(STREAM_B, 1'b0, KEY_W'(42), $urandom);
    send_word(STREAM_B, 1'b1, '0, '0);
    send_word(STREAM_B, 1'b0, KEY_W'(1), $urandom);
    send_word(STREAM_B, 1'b0, KEY_W'(2), $urandom);
    send_word(STREAM_A, 1'b0, KEY_W'(1), $urandom);
    send_word(STREAM_B, 1'b1, '0, '0);
    send_word(STREAM_A, 1'b1, '0, '0);
  endtask

  initial begin
    int pick;
    int big;
    merge_sb       = new();
    send_idle_pct  = 6;
    recv_stall_pct = 64;
    words_sent     = 0;
    quiet_cycles   = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    stream_id      = 1'b0;
    end_of_stream  = 1'b0;
    record_key     = '0;
    record_tag     = '0;
    out_stall      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
      recv_stall_pct = (phase == 0) ? 64 : (phase == 1) ? 6 : 0;
      while (words_sent < (phase + 1) * 550) begin
        pick = $urandom_range(0, 9);
        big  = ($urandom_range(0, 15) == 0) ? 40 : 10;
        if (pick < 7)
          run_merge($urandom_range(0, big), $urandom_range(0, big),
                    $urandom_range(0, 2), 1'b1);
        else if (pick == 7)
          run_merge($urandom_range(0, 10), $urandom_range(0, 10), 1, 1'b0);
        else
          run_noise($urandom_range(1, 8));
        if ($urandom_range(0, 19) == 0)
          wait_drained();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (merge_sb.mismatches == 0 && merge_sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/twsm_pkg.sv
sv/twsm_step.sv
sv/twsm_outq.sv
sv/two_way_sorted_merge.sv
tb/sv/tb_top.sv
